/* src/assert_macros.svh */
// Assertion shorthands shared by the checker files.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define LIS_ASSERT_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define LIS_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* src/lis_pkg.sv */
// Shared constants and the command type for the increasing-run engine.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package lis_pkg;

	// Storage geometry
	localparam int MAX_ITEMS  = 64;
	localparam int VALUE_BITS = 16;
	localparam int ADDR_BITS  = $clog2(MAX_ITEMS);
	localparam int CNT_BITS   = $clog2(MAX_ITEMS + 1);

	// Fixed field widths of the channels
	localparam int ELEM_BITS = 16;
	localparam int RUN_BITS  = 7;
	localparam int POS_BITS  = 6;

	// Command queue between front and back (depth must be a power of two)
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

	// One classified input item
	typedef struct packed {
		logic                  store;  // value goes into the store
		logic [ADDR_BITS-1:0]  addr;   // store slot
		logic [VALUE_BITS-1:0] value;
		logic                  last;   // closes the sequence
		logic [CNT_BITS-1:0]   count;  // entries stored after this item
		logic                  ovf;    // items were dropped in this sequence
	} cmd_t;

endpackage

`default_nettype wire

/* src/lis_channels.sv */
// Valid/ready channel interfaces for the sequence input and the run output.
// Depends on lis_pkg for field widths.
`default_nettype none

interface lis_in_if import lis_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic signed [ELEM_BITS-1:0] value;
	logic                        final_item;

	modport source (output valid, output value, output final_item, input ready);
	modport sink (input valid, input value, input final_item, output ready);
endinterface

interface lis_out_if import lis_pkg::*; ();
	logic                        valid;
	logic                        ready;
	logic [RUN_BITS-1:0]         run_length;
	logic signed [ELEM_BITS-1:0] element;
	logic [POS_BITS-1:0]         element_position;
	logic                        end_of_run;
	logic                        overflowed;

	modport source (output valid, output run_length, output element,
		output element_position, output end_of_run, output overflowed, input ready);
	modport sink (input valid, input run_length, input element,
		input element_position, input end_of_run, input overflowed, output ready);
endinterface

`default_nettype wire

/* src/lis_front.sv */
// Front end: accepts sequence transactions, tracks fill count and overflow,
// and turns each item into a command for the queue. Depends on lis_pkg.
`default_nettype none

module lis_front import lis_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	lis_in_if.sink      seq,
	input  wire         q_full,
	output logic        q_push,
	output cmd_t        q_cmd
);

	logic [CNT_BITS-1:0] cnt_q;
	logic                ovf_q;
	logic                room;

	assign seq.ready = !q_full;
	assign q_push    = seq.valid && !q_full;
	assign room      = (cnt_q < CNT_BITS'(MAX_ITEMS));

	// Classify the item: store it while there is room, else drop and flag
	always_comb begin
		q_cmd.store = room;
		q_cmd.addr  = cnt_q[ADDR_BITS-1:0];
		q_cmd.value = VALUE_BITS'(seq.value);
		q_cmd.last  = seq.final_item;
		q_cmd.count = room ? (cnt_q + CNT_BITS'(1)) : cnt_q;
		q_cmd.ovf   = ovf_q || !room;
	end

	// Advance the count; a final item starts a fresh sequence
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			ovf_q <= 1'b0;
		end else if (q_push) begin
			if (seq.final_item) begin
				cnt_q <= '0;
				ovf_q <= 1'b0;
			end else begin
				cnt_q <= q_cmd.count;
				ovf_q <= q_cmd.ovf;
			end
		end
	end

endmodule

`default_nettype wire

/* src/lis_queue.sv */
// Short command queue that decouples the front end from the engine.
// Depends on lis_pkg for cmd_t and the queue depth.
`default_nettype none

module lis_queue import lis_pkg::*; (
	input  wire   clk,
	input  wire   arst_n,
	input  wire   push,
	input  cmd_t  push_cmd,
	output logic  full,
	input  wire   pop,
	output logic  not_empty,
	output cmd_t  head_cmd
);

	cmd_t                 slots_q [QUEUE_DEPTH];
	logic [QPTR_BITS-1:0] wr_ptr_q;
	logic [QPTR_BITS-1:0] rd_ptr_q;
	logic [QCNT_BITS-1:0] used_q;

	assign full      = (used_q == QCNT_BITS'(QUEUE_DEPTH));
	assign not_empty = (used_q != '0);
	assign head_cmd  = slots_q[rd_ptr_q];

	// Hold command payloads
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_cmd;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			used_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_BITS'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_BITS'(1);
			end
			if (push && !pop) begin
				used_q <= used_q + QCNT_BITS'(1);
			end else if (pop && !push) begin
				used_q <= used_q - QCNT_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* src/lis_engine.sv */
// Back end: stores values, runs the right-to-left chain-length scan and
// walks the chosen run onto the output channel. Depends on lis_pkg.
`default_nettype none

module lis_engine import lis_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         q_vld,
	input  cmd_t        q_cmd,
	output logic        q_pop,
	lis_out_if.source   run
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DP_RD,
		ST_DP_LD,
		ST_DP_SCAN,
		ST_DP_WR,
		ST_EM_RD,
		ST_EM_LD,
		ST_SR_SCAN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Value and chain-length memories
	logic signed [VALUE_BITS-1:0] val_mem [MAX_ITEMS];
	logic [CNT_BITS-1:0]          len_mem [MAX_ITEMS];
	logic signed [VALUE_BITS-1:0] rd_val_q;
	logic [CNT_BITS-1:0]          rd_len_q;
	logic [ADDR_BITS-1:0]         rd_addr;
	logic                         val_we;
	logic                         len_we;

	// Scan control
	logic [CNT_BITS-1:0]          n_q;
	logic                         ovf_q;
	logic [ADDR_BITS-1:0]         i_q;
	logic [CNT_BITS-1:0]          j_q;
	logic                         pend_q;
	logic [ADDR_BITS-1:0]         pj_q;
	logic signed [VALUE_BITS-1:0] vi_q;
	logic [CNT_BITS-1:0]          longest_q;
	logic [CNT_BITS-1:0]          best_q;
	logic [ADDR_BITS-1:0]         start_q;
	logic [CNT_BITS-1:0]          need_q;
	logic                         found_q;
	logic [ADDR_BITS-1:0]         fj_q;
	logic signed [VALUE_BITS-1:0] fv_q;
	logic [ADDR_BITS-1:0]         cur_q;
	logic                         dp_issue;
	logic                         sr_issue;
	logic                         larger;
	logic [CNT_BITS-1:0]          new_len;

	// Output register
	logic                         out_vld_q;
	logic [RUN_BITS-1:0]          out_len_q;
	logic [ELEM_BITS-1:0]         out_elem_q;
	logic [POS_BITS-1:0]          out_pos_q;
	logic                         out_end_q;
	logic                         out_ovf_q;
	logic                         out_free;

	assign q_pop    = (state_q == ST_IDLE) && q_vld;
	assign val_we   = q_pop && q_cmd.store;
	assign len_we   = (state_q == ST_DP_WR);
	assign new_len  = longest_q + CNT_BITS'(1);
	assign dp_issue = (j_q < n_q);
	assign sr_issue = (j_q < n_q) && (need_q != '0);
	assign larger   = (rd_val_q > vi_q);
	assign out_free = !out_vld_q || run.ready;

	always_comb begin
		case (state_q)
			ST_DP_RD: rd_addr = i_q;
			ST_EM_RD: rd_addr = start_q;
			default:  rd_addr = j_q[ADDR_BITS-1:0];
		endcase
	end

	// Value store: written from commands, read one entry per cycle
	always_ff @(posedge clk) begin
		if (val_we) begin
			val_mem[q_cmd.addr] <= q_cmd.value;
		end
		rd_val_q <= val_mem[rd_addr];
	end

	// Chain-length store: written once per index during the scan
	always_ff @(posedge clk) begin
		if (len_we) begin
			len_mem[i_q] <= new_len;
		end
		rd_len_q <= len_mem[rd_addr];
	end

	assign run.valid            = out_vld_q;
	assign run.run_length       = out_len_q;
	assign run.element          = out_elem_q;
	assign run.element_position = out_pos_q;
	assign run.end_of_run       = out_end_q;
	assign run.overflowed       = out_ovf_q;

	// Sequence the length scan, the run walk and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			n_q        <= '0;
			ovf_q      <= 1'b0;
			i_q        <= '0;
			j_q        <= '0;
			pend_q     <= 1'b0;
			pj_q       <= '0;
			vi_q       <= '0;
			longest_q  <= '0;
			best_q     <= '0;
			start_q    <= '0;
			need_q     <= '0;
			found_q    <= 1'b0;
			fj_q       <= '0;
			fv_q       <= '0;
			cur_q      <= '0;
			out_vld_q  <= 1'b0;
			out_len_q  <= '0;
			out_elem_q <= '0;
			out_pos_q  <= '0;
			out_end_q  <= 1'b0;
			out_ovf_q  <= 1'b0;
		end else begin
			// Drop the output once the receiver takes it; the emit state reloads it
			if (run.ready && (state_q != ST_EMIT)) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (q_vld && q_cmd.last) begin
						n_q     <= q_cmd.count;
						ovf_q   <= q_cmd.ovf;
						i_q     <= ADDR_BITS'(q_cmd.count - CNT_BITS'(1));
						best_q  <= '0;
						state_q <= ST_DP_RD;
					end
				end
				ST_DP_RD: begin
					state_q <= ST_DP_LD;
				end
				ST_DP_LD: begin
					vi_q      <= rd_val_q;
					longest_q <= '0;
					j_q       <= CNT_BITS'(i_q) + CNT_BITS'(1);
					pend_q    <= 1'b0;
					state_q   <= ST_DP_SCAN;
				end
				ST_DP_SCAN: begin
					// Best length among later, larger values
					if (pend_q && larger && (rd_len_q > longest_q)) begin
						longest_q <= rd_len_q;
					end
					pend_q <= dp_issue;
					if (dp_issue) begin
						j_q <= j_q + CNT_BITS'(1);
					end else if (!pend_q) begin
						state_q <= ST_DP_WR;
					end
				end
				ST_DP_WR: begin
					// Moving leftward, ties go to the earlier index
					if (new_len >= best_q) begin
						best_q  <= new_len;
						start_q <= i_q;
					end
					if (i_q == '0) begin
						state_q <= ST_EM_RD;
					end else begin
						i_q     <= i_q - ADDR_BITS'(1);
						state_q <= ST_DP_RD;
					end
				end
				ST_EM_RD: begin
					state_q <= ST_EM_LD;
				end
				ST_EM_LD: begin
					vi_q    <= rd_val_q;
					cur_q   <= start_q;
					need_q  <= best_q - CNT_BITS'(1);
					j_q     <= CNT_BITS'(start_q) + CNT_BITS'(1);
					pend_q  <= 1'b0;
					state_q <= ST_SR_SCAN;
				end
				ST_SR_SCAN: begin
					// Earliest later, larger index one step shorter
					if (pend_q && larger && (rd_len_q == need_q)) begin
						found_q <= 1'b1;
						fj_q    <= pj_q;
						fv_q    <= rd_val_q;
						pend_q  <= 1'b0;
						state_q <= ST_EMIT;
					end else if (!sr_issue && !pend_q) begin
						found_q <= 1'b0;
						state_q <= ST_EMIT;
					end else begin
						pend_q <= sr_issue;
						pj_q   <= j_q[ADDR_BITS-1:0];
						if (sr_issue) begin
							j_q <= j_q + CNT_BITS'(1);
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						out_vld_q  <= 1'b1;
						out_len_q  <= RUN_BITS'(best_q);
						out_elem_q <= ELEM_BITS'($unsigned(vi_q));
						out_pos_q  <= POS_BITS'(cur_q);
						out_end_q  <= !found_q;
						out_ovf_q  <= ovf_q;
						if (found_q) begin
							cur_q   <= fj_q;
							vi_q    <= fv_q;
							need_q  <= need_q - CNT_BITS'(1);
							j_q     <= CNT_BITS'(fj_q) + CNT_BITS'(1);
							pend_q  <= 1'b0;
							state_q <= ST_SR_SCAN;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

/* src/longest_increasing_subsequence.sv */
// Longest strictly increasing subsequence engine, top level.
// Channels: seq takes one signed value per transaction, with final_item
// marking the end of a sequence; run returns the chosen subsequence, one
// element per transaction, in order, with its index, the run length, an
// end_of_run mark on the last element and an overflowed flag.
// Up to 64 values are kept; further items in a sequence are dropped and
// reported through overflowed.
// Loading: one item per cycle while the queue has room, buffered by a
// four-entry command queue. The final item starts the length scan, which
// visits every later entry for each index through the single read port of
// the value memory. The run walk then scans the later entries again to find
// each next element of the run.
// New items keep loading into the queue while the engine works; seq.ready
// drops only when the queue is full.
// Reset clears the count, the overflow flag, the queue and the output
// register; the memories are not cleared. A stalled receiver holds the
// current result and stops the walk; nothing is lost.
`default_nettype none

module longest_increasing_subsequence import lis_pkg::*; (
	input  wire        clk,
	input  wire        arst_n,
	lis_in_if.sink     seq,
	lis_out_if.source  run
);

	logic q_full;
	logic q_push;
	cmd_t q_push_cmd;
	logic q_vld;
	cmd_t q_head_cmd;
	logic q_pop;

	lis_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.seq    (seq),
		.q_full (q_full),
		.q_push (q_push),
		.q_cmd  (q_push_cmd)
	);

	lis_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (q_push_cmd),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_vld),
		.head_cmd  (q_head_cmd)
	);

	lis_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.q_vld  (q_vld),
		.q_cmd  (q_head_cmd),
		.q_pop  (q_pop),
		.run    (run)
	);

endmodule

`default_nettype wire

/* src/lis_checker.sv */
// Port-level checks on the run channel of the top level, bound in below.
// Depends on lis_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module lis_checker import lis_pkg::*; (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        run_valid,
	input wire                        run_ready,
	input wire [RUN_BITS-1:0]         run_length,
	input wire signed [ELEM_BITS-1:0] element,
	input wire [POS_BITS-1:0]         element_position,
	input wire                        end_of_run
);

	logic                        acc;
	logic                        mid_q;
	logic [POS_BITS-1:0]         last_pos_q;
	logic signed [ELEM_BITS-1:0] last_elem_q;
	logic [RUN_BITS-1:0]         last_len_q;

	assign acc = run_valid && run_ready;

	// Track the previous transaction of the current run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q       <= 1'b0;
			last_pos_q  <= '0;
			last_elem_q <= '0;
			last_len_q  <= '0;
		end else if (acc) begin
			mid_q       <= !end_of_run;
			last_pos_q  <= element_position;
			last_elem_q <= element;
			last_len_q  <= run_length;
		end
	end

	`LIS_ASSERT_NEXT(a_hold_valid, run_valid && !run_ready, run_valid, "run valid dropped under stall")
	`LIS_ASSERT_NEXT(a_hold_data, run_valid && !run_ready, $stable(element) && $stable(element_position) && $stable(end_of_run), "run payload changed under stall")
	`LIS_ASSERT_NOW(a_run_order, acc && mid_q, (element_position > last_pos_q) && (element > last_elem_q) && (run_length == last_len_q), "run elements not strictly increasing")
	`LIS_ASSERT_NOW(a_len_range, run_valid, (run_length != '0) && (run_length <= RUN_BITS'(MAX_ITEMS)), "run length out of range")

endmodule

bind longest_increasing_subsequence lis_checker u_lis_checker (
	.clk              (clk),
	.arst_n           (arst_n),
	.run_valid        (run.valid),
	.run_ready        (run.ready),
	.run_length       (run.run_length),
	.element          (run.element),
	.element_position (run.element_position),
	.end_of_run       (run.end_of_run)
);

`default_nettype wire
